// ----- src/i2cbs_pkg.sv -----
package i2cbs_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [15:0] PhaseTicksReset = 16'd20;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_ACK   = 3'd3,
    OP_MACK  = 3'd4,
    OP_WRITE = 3'd5,
    OP_READ  = 3'd6
  } op_t;

  // line codes: bit 3 pulls SCL low, bit 1 pulls SDA low
  localparam logic [3:0] LvSclLoSdaHi = 4'h0C;
  localparam logic [3:0] LvBothLo     = 4'h0E;
  localparam logic [3:0] LvSclHiSdaLo = 4'h06;
  localparam logic [3:0] LvBothHi     = 4'h04;
  localparam logic [3:0] LvClkHiMask  = 4'h07;
  localparam logic [3:0] LvClkLoBit   = 4'h08;
  localparam logic [3:0] SdaPullBit   = 4'h02;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       sda_in;
  } entry_t;

  function automatic logic [4:0] seq_len(op_t op);
    logic [4:0] len;
    unique case (op)
      OP_START: len = 5'd2;
      OP_STOP:  len = 5'd3;
      OP_ACK:   len = 5'd3;
      OP_MACK:  len = 5'd4;
      OP_WRITE: len = 5'd24;
      OP_READ:  len = 5'd16;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] seq_code(op_t op, logic [4:0] step, logic [7:0] sb);
    logic [2:0] q;
    logic [4:0] r;
    logic [3:0] base;
    logic [3:0] code;
    q = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (step >= 5'(3 * k)) q = q + 3'd1;
    end
    r = step - {1'b0, q, 1'b0} - {2'b00, q};
    base = sb[3'd7 - q] ? LvSclLoSdaHi : LvBothLo;
    unique case (op)
      OP_START: code = step[0] ? LvBothLo : LvSclHiSdaLo;
      OP_STOP: begin
        if (step == 5'd0) code = LvBothLo;
        else if (step == 5'd1) code = LvSclHiSdaLo;
        else code = LvBothHi;
      end
      OP_ACK: begin
        if (step == 5'd1) code = LvBothHi;
        else code = LvSclLoSdaHi;
      end
      OP_MACK: begin
        unique case (step[1:0])
          2'd0:    code = LvBothLo;
          2'd1:    code = LvSclHiSdaLo;
          2'd2:    code = LvBothLo;
          default: code = LvSclLoSdaHi;
        endcase
      end
      OP_WRITE: code = (r == 5'd1) ? (base & LvClkHiMask) : (base | LvClkLoBit);
      OP_READ:  code = step[0] ? LvSclLoSdaHi : LvBothHi;
      default:  code = LvBothHi;
    endcase
    return code;
  endfunction

endpackage

// ----- src/i2cbs_front.sv -----
module i2cbs_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cbs_pkg::in_item_t in_item,
  input  logic                full,
  output logic                push,
  output i2cbs_pkg::entry_t   entry
);
  import i2cbs_pkg::*;

  op_t op;

  always_comb begin
    unique case (in_item.cmd)
      OP_START: op = OP_START;
      OP_STOP:  op = OP_STOP;
      OP_ACK:   op = OP_ACK;
      OP_MACK:  op = OP_MACK;
      OP_WRITE: op = OP_WRITE;
      OP_READ:  op = OP_READ;
      default:  op = OP_IDLE;
    endcase
  end

  assign in_ready        = !full;
  assign push            = in_valid && !full;
  assign entry.op        = op;
  assign entry.data_byte = (op == OP_WRITE) ? in_item.data_byte : 8'd0;
  assign entry.sda_in    = in_item.sda_in;

endmodule

// ----- src/i2cbs_queue.sv -----
module i2cbs_queue #(
  parameter int unsigned DEPTH = i2cbs_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2cbs_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output i2cbs_pkg::entry_t q_entry
);
  import i2cbs_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/i2cbs_back.sv -----
module i2cbs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          phase_ticks,
  input  logic                 q_valid,
  input  i2cbs_pkg::entry_t    q_entry,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cbs_pkg::out_item_t out_item
);
  import i2cbs_pkg::*;

  op_t        active_op, active_op_next;
  logic [4:0] step_index, step_index_next;
  logic [15:0] hold_count, hold_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       scl_lv, scl_lv_next;
  logic       sda_lv, sda_lv_next;
  logic [7:0] read_latch, read_latch_next;
  logic       done;
  logic [15:0] first_hold;
  logic [4:0] step_inc;
  logic [3:0] code;
  logic       drive_en;

  assign first_hold = (phase_ticks == 16'd0) ? 16'd0 : phase_ticks - 16'd1;
  assign step_inc   = step_index + 5'd1;
  assign pop        = q_valid && (!out_valid || out_ready);

  // next state
  always_comb begin
    active_op_next  = active_op;
    step_index_next = step_index;
    hold_count_next = hold_count;
    shift_byte_next = shift_byte;
    read_latch_next = read_latch;
    done            = 1'b0;
    drive_en        = 1'b0;
    code            = LvBothHi;
    if (active_op == OP_IDLE) begin
      if (q_entry.op != OP_IDLE) begin
        active_op_next  = q_entry.op;
        step_index_next = 5'd0;
        shift_byte_next = q_entry.data_byte;
        hold_count_next = first_hold;
        drive_en        = 1'b1;
        code            = seq_code(q_entry.op, 5'd0, q_entry.data_byte);
      end
    end else if (hold_count != 16'd0) begin
      hold_count_next = hold_count - 16'd1;
    end else begin
      if (active_op == OP_READ && !step_index[0]) begin
        shift_byte_next = {shift_byte[6:0], q_entry.sda_in};
      end
      if (step_inc >= seq_len(active_op)) begin
        if (active_op == OP_READ) begin
          read_latch_next = shift_byte_next;
        end
        active_op_next  = OP_IDLE;
        step_index_next = 5'd0;
        done            = 1'b1;
      end else begin
        step_index_next = step_inc;
        hold_count_next = first_hold;
        drive_en        = 1'b1;
        code            = seq_code(active_op, step_inc, shift_byte);
      end
    end
  end

  // line outputs
  always_comb begin
    scl_lv_next = scl_lv;
    sda_lv_next = sda_lv;
    if (drive_en) begin
      scl_lv_next = ((code & LvClkLoBit) == 4'd0);
      sda_lv_next = ((code & SdaPullBit) == 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_op  <= OP_IDLE;
      step_index <= '0;
      hold_count <= '0;
      shift_byte <= '0;
      scl_lv     <= 1'b1;
      sda_lv     <= 1'b1;
      read_latch <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        active_op  <= active_op_next;
        step_index <= step_index_next;
        hold_count <= hold_count_next;
        shift_byte <= shift_byte_next;
        scl_lv     <= scl_lv_next;
        sda_lv     <= sda_lv_next;
        read_latch <= read_latch_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.scl       <= scl_lv_next;
      out_item.sda       <= sda_lv_next;
      out_item.busy_res  <= (active_op_next != OP_IDLE);
      out_item.done_res  <= done;
      out_item.read_byte <= read_latch_next;
    end
  end

endmodule

// ----- src/i2c_master_bit_sequencer_top.sv -----
// I2C master bit sequencer.
// in_item carries one bus tick: cmd, data_byte and sda_in. Each accepted
// item yields exactly one out_item with the SCL/SDA levels, busy, done and
// the last read byte. Commands are taken only while no sequence runs.
// cfg_we/cfg_wdata set phase_ticks, the ticks each level pair is held;
// write it only while the block is idle.
// Path: an accepted item is written into the input queue and popped once the
// output register is free or being taken, loading its result there.
// Throughput: one item per cycle while out_ready is high, set by the
// sequencer updating its state once per item; the queue lets input and
// output stall independently.
// Reset: phase_ticks returns to 20, the sequencer idles with both lines
// high, the queue and output register are emptied.
// When out_ready is low the result is held, the queue fills, and in_ready
// drops once the queue is full.
module i2c_master_bit_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = i2cbs_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cbs_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cbs_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import i2cbs_pkg::*;

  logic [15:0] phase_ticks;
  logic        full;
  logic        push;
  entry_t      push_entry;
  logic        pop;
  logic        q_valid;
  entry_t      q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PhaseTicksReset;
    end else if (cfg_we) begin
      phase_ticks <= cfg_wdata;
    end
  end

  i2cbs_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .full     (full),
    .push     (push),
    .entry    (push_entry)
  );

  i2cbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  i2cbs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .phase_ticks (phase_ticks),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import i2cbs_pkg::*;

  localparam logic [2:0] CmdUnused = 3'd7;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    logic        set_cfg;
    logic [15:0] cfg_val;
    in_item_t    item;
    logic        check;
    out_item_t   want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  bit          quiet = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  out_item_t   pending_levels [$];
  out_item_t   want_now;
  dir_row_t    dir_rows [$];

  // predictor state
  logic [15:0] phase_len = PhaseTicksReset;
  op_t         cur_op = OP_IDLE;
  logic [4:0]  cur_step = '0;
  logic [15:0] hold_left = '0;
  logic [7:0]  shreg = '0;
  logic [7:0]  rd_latch = '0;
  logic        scl_lvl = 1'b1;
  logic        sda_lvl = 1'b1;

  i2c_master_bit_sequencer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int steps_in(op_t op);
    case (op)
      OP_START: return 2;
      OP_STOP:  return 3;
      OP_ACK:   return 3;
      OP_MACK:  return 4;
      OP_WRITE: return 24;
      OP_READ:  return 16;
      default:  return 0;
    endcase
  endfunction

  function automatic logic [3:0] pair_code(op_t op, int stp, logic [7:0] sb);
    logic [3:0] base;
    case (op)
      OP_START: return stp[0] ? LvBothLo : LvSclHiSdaLo;
      OP_STOP: begin
        if (stp == 0) return LvBothLo;
        if (stp == 1) return LvSclHiSdaLo;
        return LvBothHi;
      end
      OP_ACK: return (stp == 1) ? LvBothHi : LvSclLoSdaHi;
      OP_MACK: begin
        case (stp % 4)
          0: return LvBothLo;
          1: return LvSclHiSdaLo;
          2: return LvBothLo;
          default: return LvSclLoSdaHi;
        endcase
      end
      OP_WRITE: begin
        base = sb[7 - (stp / 3)] ? LvSclLoSdaHi : LvBothLo;
        return (stp % 3 == 1) ? (base & LvClkHiMask) : (base | LvClkLoBit);
      end
      OP_READ: return stp[0] ? LvSclLoSdaHi : LvBothHi;
      default: return LvBothHi;
    endcase
  endfunction

  // one bus tick of the sequencer
  function automatic out_item_t next_bus_levels(in_item_t it);
    out_item_t  res;
    logic       fin;
    logic       load;
    logic [3:0] code;
    fin = 1'b0;
    load = 1'b0;
    if (cur_op == OP_IDLE) begin
      if (it.cmd >= OP_START && it.cmd <= OP_READ) begin
        cur_op = op_t'(it.cmd);
        cur_step = '0;
        shreg = (cur_op == OP_WRITE) ? it.data_byte : 8'h00;
        load = 1'b1;
      end
    end else if (hold_left != 16'd0) begin
      hold_left = hold_left - 16'd1;
    end else begin
      if (cur_op == OP_READ && !cur_step[0]) shreg = {shreg[6:0], it.sda_in};
      cur_step = cur_step + 5'd1;
      if (int'(cur_step) >= steps_in(cur_op)) begin
        if (cur_op == OP_READ) rd_latch = shreg;
        cur_op = OP_IDLE;
        cur_step = '0;
        fin = 1'b1;
      end else begin
        load = 1'b1;
      end
    end
    if (load) begin
      hold_left = (phase_len == 16'd0) ? 16'd0 : phase_len - 16'd1;
      code = pair_code(cur_op, int'(cur_step), shreg);
      scl_lvl = ((code & LvClkLoBit) == 4'd0);
      sda_lvl = ((code & SdaPullBit) == 4'd0);
    end
    res.scl = scl_lvl;
    res.sda = sda_lvl;
    res.busy_res = (cur_op != OP_IDLE);
    res.done_res = fin;
    res.read_byte = rd_latch;
    return res;
  endfunction

  function automatic dir_row_t dir_row(logic set_cfg, logic [15:0] cfg_val, logic [2:0] cmd,
                                       logic [7:0] data, logic sda, logic check,
                                       out_item_t want);
    dir_row_t r;
    r.set_cfg = set_cfg;
    r.cfg_val = cfg_val;
    r.item.cmd = cmd;
    r.item.data_byte = data;
    r.item.sda_in = sda;
    r.check = check;
    r.want = want;
    return r;
  endfunction

  task automatic send_tick(input in_item_t it, input logic fixed, input out_item_t want);
    out_item_t pred;
    while (!quiet && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pred = next_bus_levels(it);
    pending_levels.push_back(fixed ? want : pred);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // issue one item, then keep ticking until the sequence has finished
  task automatic run_cmd(input in_item_t it, input logic fixed, input out_item_t want,
                         input logic rand_fill);
    in_item_t f;
    send_tick(it, fixed, want);
    while (cur_op != OP_IDLE) begin
      if (rand_fill) begin
        f.cmd = 3'($urandom_range(7));
        f.data_byte = 8'($urandom);
        f.sda_in = 1'($urandom);
      end else begin
        f.cmd = it.cmd;
        f.data_byte = ~it.data_byte;
        f.sda_in = it.sda_in;
      end
      send_tick(f, 1'b0, '0);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_phase(input logic [15:0] v);
    wait_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    phase_len = v;
  endtask

  task automatic run_random(input logic [15:0] ph, input int n_cmds);
    in_item_t it;
    int       taken;
    set_phase(ph);
    taken = 0;
    while (taken < n_cmds) begin
      it.data_byte = 8'($urandom);
      it.sda_in = 1'($urandom);
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1) == 0) it.cmd = OP_IDLE;
        else it.cmd = CmdUnused;
      end else begin
        it.cmd = 3'($urandom_range(int'(OP_READ), int'(OP_START)));
        taken++;
      end
      run_cmd(it, 1'b0, '0, 1'b1);
    end
  endtask

  task automatic flag_mismatch(input string what, input out_item_t w, input out_item_t g);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want %h got %h", $time, what, w, g);
  endtask

  always @(posedge clk) out_ready <= quiet || ($urandom_range(99) >= 34);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        flag_mismatch("item with nothing pending", '0, out_item);
      end else begin
        want_now = pending_levels.pop_front();
        if (out_item.scl !== want_now.scl || out_item.sda !== want_now.sda ||
            out_item.busy_res !== want_now.busy_res ||
            out_item.done_res !== want_now.done_res ||
            out_item.read_byte !== want_now.read_byte)
          flag_mismatch("mismatch", want_now, out_item);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL i2c_master_bit_sequencer_top");
      $finish;
    end
  end

  initial begin
    in_item_t big;
    dir_rows = '{
      dir_row(1'b0, 16'd0, OP_IDLE,   8'h00, 1'b0, 1'b1, out_item_t'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}),
      dir_row(1'b1, 16'd1, OP_START,  8'h00, 1'b0, 1'b1, out_item_t'{1'b1, 1'b0, 1'b1, 1'b0, 8'h00}),
      dir_row(1'b0, 16'd0, OP_WRITE,  8'hFF, 1'b0, 1'b1, out_item_t'{1'b0, 1'b1, 1'b1, 1'b0, 8'h00}),
      dir_row(1'b0, 16'd0, OP_ACK,    8'h00, 1'b0, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_WRITE,  8'h00, 1'b1, 1'b1, out_item_t'{1'b0, 1'b0, 1'b1, 1'b0, 8'h00}),
      dir_row(1'b0, 16'd0, OP_ACK,    8'h00, 1'b1, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_MACK,   8'h00, 1'b0, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_READ,   8'h00, 1'b1, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_MACK,   8'hFF, 1'b1, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_READ,   8'hFF, 1'b0, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_STOP,   8'h00, 1'b0, 1'b0, '0),
      dir_row(1'b0, 16'd0, CmdUnused, 8'hFF, 1'b1, 1'b1, out_item_t'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00}),
      dir_row(1'b1, 16'd0, OP_START,  8'h00, 1'b0, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_WRITE,  8'hA5, 1'b0, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_READ,   8'h00, 1'b1, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_STOP,   8'h00, 1'b1, 1'b0, '0),
      dir_row(1'b1, 16'd2, OP_START,  8'h00, 1'b0, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_WRITE,  8'h5A, 1'b1, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_ACK,    8'h00, 1'b0, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_READ,   8'hFF, 1'b0, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_MACK,   8'h00, 1'b1, 1'b0, '0),
      dir_row(1'b0, 16'd0, OP_STOP,   8'h00, 1'b0, 1'b0, '0)
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) set_phase(dir_rows[i].cfg_val);
      run_cmd(dir_rows[i].item, dir_rows[i].check, dir_rows[i].want, 1'b0);
    end

    run_random(16'd1, 25);
    quiet = 1'b1;
    run_random(16'd1, 15);
    quiet = 1'b0;
    run_random(16'd2, 6);
    run_random(16'd3, 3);
    run_random(16'($urandom_range(9, 4)), 1);
    run_random(16'd0, 4);

    // long hold: a single start only
    set_phase(16'd60);
    quiet = 1'b1;
    big.cmd = OP_START;
    big.data_byte = 8'($urandom);
    big.sda_in = 1'($urandom);
    run_cmd(big, 1'b0, '0, 1'b1);
    quiet = 1'b0;
    run_random(16'd1, 10);

    wait_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("PASS i2c_master_bit_sequencer_top");
    end else begin
      $display("FAIL i2c_master_bit_sequencer_top");
    end
    $finish;
  end

endmodule
